// ----- sv/bpit_pkg.sv -----
// Shared types and constants for the barycentric point-in-triangle block.
// Used by bpit_div, barycentric_point_in_triangle and the testbench; depends on nothing.
`timescale 1ns / 1ps

package bpit_pkg;

	// Fixed field widths.
	localparam int COORD_W = 16;
	localparam int WEIGHT_W = 16;

	// Default number of fraction bits in a weight.
	localparam int WEIGHT_FRAC_DEF = 14;

	// Width of a cross-product magnitude: |na| stays below 3 * 2^33.
	localparam int MAG_W = 36;

	// Quotient bits taken per weight: sixteen result bits and one rounding bit.
	localparam int QUO_BITS = WEIGHT_W + 1;

	// Depth of the weight divider: setup stage, one stage per quotient bit,
	// then the rounding and saturation stage.
	localparam int DIV_LAT = QUO_BITS + 2;

	// One input transaction: query point and the three triangle vertices.
	typedef struct packed {
		logic [COORD_W-1:0] point_u;
		logic [COORD_W-1:0] point_v;
		logic [COORD_W-1:0] vert_a_u;
		logic [COORD_W-1:0] vert_a_v;
		logic [COORD_W-1:0] vert_b_u;
		logic [COORD_W-1:0] vert_b_v;
		logic [COORD_W-1:0] vert_c_u;
		logic [COORD_W-1:0] vert_c_v;
	} pt_t;

	// One result transaction: three weights and two flags.
	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight_a;
		logic signed [WEIGHT_W-1:0] weight_b;
		logic signed [WEIGHT_W-1:0] weight_c;
		logic                       inside_res;
		logic                       degenerate;
	} wt_t;

endpackage

// ----- sv/bpit_div.sv -----
// Pipelined restoring divider that turns one numerator magnitude and sign into a
// rounded, saturated signed weight. Depends on bpit_pkg.
`timescale 1ns / 1ps

module bpit_div #(
	parameter int WFRAC = bpit_pkg::WEIGHT_FRAC_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [bpit_pkg::MAG_W-1:0]        mag,
	input  logic [bpit_pkg::MAG_W-1:0]        den,
	input  logic                              neg,
	output logic signed [bpit_pkg::WEIGHT_W-1:0] weight
);

	localparam int QB = bpit_pkg::QUO_BITS;
	localparam int OW = bpit_pkg::WEIGHT_W;
	localparam int XW = bpit_pkg::MAG_W + QB + WFRAC + 1;
	localparam logic [QB:0] POS_MAX = (QB+1)'((2 ** (OW - 1)) - 1);
	localparam logic [QB:0] NEG_MAX = (QB+1)'(2 ** (OW - 1));

	// Per-stage state; index k holds the value after k quotient bits.
	logic [XW-1:0] rem_s [QB+1];
	logic [XW-1:0] den_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic          ovf_s [QB+1];
	logic          neg_s [QB+1];

	logic [XW-1:0] num;
	logic [QB:0]   rnd;
	logic [OW-1:0] wsel;

	// Setup stage: scale the numerator by 2^(WFRAC+1) and flag a quotient that
	// does not fit in the taken bits.
	assign num = XW'(mag) << (WFRAC + 1);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= XW'(den);
			quo_s[0] <= '0;
			ovf_s[0] <= num >= (XW'(den) << QB);
			neg_s[0] <= neg;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar k = 1; k <= QB; k++) begin : g_bit
		localparam int SH = QB - k;
		logic [XW:0] trial;

		assign trial = {1'b0, rem_s[k-1]} - {1'b0, den_s[k-1] << SH};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= trial[XW] ? rem_s[k-1] : trial[XW-1:0];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= {quo_s[k-1][QB-2:0], ~trial[XW]};
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// Round half away from zero: the quotient carries one extra bit.
	assign rnd = ({1'b0, quo_s[QB]} + (QB+1)'(1)) >> 1;

	// Saturate to the signed output range and apply the sign.
	always_comb begin
		if (neg_s[QB]) begin
			if (ovf_s[QB] || (rnd > NEG_MAX)) begin
				wsel = OW'(NEG_MAX);
			end else begin
				wsel = OW'(0) - rnd[OW-1:0];
			end
		end else begin
			if (ovf_s[QB] || (rnd > POS_MAX)) begin
				wsel = OW'(POS_MAX);
			end else begin
				wsel = rnd[OW-1:0];
			end
		end
	end

	// Output stage.
	always_ff @(posedge clk) begin
		if (en) begin
			weight <= $signed(wsel);
		end
	end

endmodule

// ----- sv/barycentric_point_in_triangle.sv -----
// Top level of the barycentric point-in-triangle block: edge vectors, cross
// products, sign normalization and three weight dividers. Depends on bpit_pkg, bpit_div.
`timescale 1ns / 1ps
//
//  channel | signals                  | direction | content
//  --------+--------------------------+-----------+------------------------------
//  pt      | pt_valid, pt_stall, pt   | in        | query point and three vertices
//  wt      | wt_valid, wt_stall, wt   | out       | three weights, inside, degenerate
//
// One transaction enters per cycle while no result is stalled; each result passes six
// arithmetic stages and then 19 divider stages, one stage per quotient bit (17)
// and one each for setup and rounding.
// Reset clears only the valid bits; data registers are not reset.
// A stalled result freezes the whole pipeline, and pt_stall follows it.

module barycentric_point_in_triangle #(
	parameter int WEIGHT_FRAC_BITS = bpit_pkg::WEIGHT_FRAC_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pt_valid,
	output logic           pt_stall,
	input  bpit_pkg::pt_t  pt,
	output logic           wt_valid,
	input  logic           wt_stall,
	output bpit_pkg::wt_t  wt
);

	localparam int MW = bpit_pkg::MAG_W;
	localparam int LAT = bpit_pkg::DIV_LAT;
	localparam int EW = bpit_pkg::COORD_W + 1;
	localparam int PW = 2 * EW;
	localparam int CW = PW + 1;

	typedef struct packed {
		logic in_tri;
		logic degen;
	} side_t;

	logic en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_q [LAT];
	side_t side_q [LAT];

	logic signed [EW-1:0] e0u_s1, e0v_s1, e1u_s1, e1v_s1, e2u_s1, e2v_s1;
	logic signed [PW-1:0] pd1_s2, pd2_s2, pb1_s2, pb2_s2, pc1_s2, pc2_s2;
	logic signed [CW-1:0] d_s3, nb_s3, nc_s3;
	logic signed [MW-1:0] dn_s4, nb_s4, nc_s4;
	logic                 degen_s4;
	logic signed [MW-1:0] dn_s5, nb_s5, nc_s5, na_s5;
	logic                 degen_s5;
	logic [MW-1:0]        den_s6, ma_s6, mb_s6, mc_s6;
	logic                 sa_s6, sb_s6, sc_s6;
	side_t                side_s6;

	logic signed [bpit_pkg::WEIGHT_W-1:0] wa, wb, wc;

	// The pipeline moves whenever the output register can take a result.
	assign en = ~(wt_valid & wt_stall);
	assign pt_stall = wt_valid & wt_stall;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1 <= pt_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_q[0] <= vld_s6;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Stage 1: edge vectors relative to vertex A.
	always_ff @(posedge clk) begin
		if (en) begin
			e0u_s1 <= $signed({1'b0, pt.vert_b_u}) - $signed({1'b0, pt.vert_a_u});
			e0v_s1 <= $signed({1'b0, pt.vert_b_v}) - $signed({1'b0, pt.vert_a_v});
			e1u_s1 <= $signed({1'b0, pt.vert_c_u}) - $signed({1'b0, pt.vert_a_u});
			e1v_s1 <= $signed({1'b0, pt.vert_c_v}) - $signed({1'b0, pt.vert_a_v});
			e2u_s1 <= $signed({1'b0, pt.point_u}) - $signed({1'b0, pt.vert_a_u});
			e2v_s1 <= $signed({1'b0, pt.point_v}) - $signed({1'b0, pt.vert_a_v});
		end
	end

	// Stage 2: the six partial products of the three cross products.
	always_ff @(posedge clk) begin
		if (en) begin
			pd1_s2 <= e0u_s1 * e1v_s1;
			pd2_s2 <= e0v_s1 * e1u_s1;
			pb1_s2 <= e2u_s1 * e1v_s1;
			pb2_s2 <= e2v_s1 * e1u_s1;
			pc1_s2 <= e0u_s1 * e2v_s1;
			pc2_s2 <= e0v_s1 * e2u_s1;
		end
	end

	// Stage 3: determinant and the weight numerators of B and C.
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3  <= CW'(pd1_s2) - CW'(pd2_s2);
			nb_s3 <= CW'(pb1_s2) - CW'(pb2_s2);
			nc_s3 <= CW'(pc1_s2) - CW'(pc2_s2);
		end
	end

	// Stage 4: flip all signs for a clockwise triangle so the determinant is positive.
	always_ff @(posedge clk) begin
		if (en) begin
			degen_s4 <= (d_s3 == '0);
			dn_s4 <= d_s3[CW-1] ? -MW'(d_s3) : MW'(d_s3);
			nb_s4 <= d_s3[CW-1] ? -MW'(nb_s3) : MW'(nb_s3);
			nc_s4 <= d_s3[CW-1] ? -MW'(nc_s3) : MW'(nc_s3);
		end
	end

	// Stage 5: numerator of A from the other two.
	always_ff @(posedge clk) begin
		if (en) begin
			na_s5 <= dn_s4 - nb_s4 - nc_s4;
			dn_s5 <= dn_s4;
			nb_s5 <= nb_s4;
			nc_s5 <= nc_s4;
			degen_s5 <= degen_s4;
		end
	end

	// Stage 6: magnitudes and signs for the dividers, and the inside test.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= dn_s5;
			ma_s6 <= na_s5[MW-1] ? -na_s5 : na_s5;
			mb_s6 <= nb_s5[MW-1] ? -nb_s5 : nb_s5;
			mc_s6 <= nc_s5[MW-1] ? -nc_s5 : nc_s5;
			sa_s6 <= na_s5[MW-1];
			sb_s6 <= nb_s5[MW-1];
			sc_s6 <= nc_s5[MW-1];
			side_s6.in_tri <= ~degen_s5 & ~na_s5[MW-1] & ~nb_s5[MW-1] & ~nc_s5[MW-1];
			side_s6.degen <= degen_s5;
		end
	end

	// Flags ride alongside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s6;
			for (int i = 1; i < LAT; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// One divider per weight.
	bpit_div #(.WFRAC(WEIGHT_FRAC_BITS)) u_div_a (
		.clk(clk), .en(en), .mag(ma_s6), .den(den_s6), .neg(sa_s6), .weight(wa)
	);

	bpit_div #(.WFRAC(WEIGHT_FRAC_BITS)) u_div_b (
		.clk(clk), .en(en), .mag(mb_s6), .den(den_s6), .neg(sb_s6), .weight(wb)
	);

	bpit_div #(.WFRAC(WEIGHT_FRAC_BITS)) u_div_c (
		.clk(clk), .en(en), .mag(mc_s6), .den(den_s6), .neg(sc_s6), .weight(wc)
	);

	// Result; a degenerate triangle reports zero weights.
	assign wt_valid = vld_q[LAT-1];
	assign wt.weight_a = side_q[LAT-1].degen ? '0 : wa;
	assign wt.weight_b = side_q[LAT-1].degen ? '0 : wb;
	assign wt.weight_c = side_q[LAT-1].degen ? '0 : wc;
	assign wt.inside_res = side_q[LAT-1].in_tri;
	assign wt.degenerate = side_q[LAT-1].degen;

`ifndef ASSERT_OFF
	// A degenerate result never claims the point inside.
	a_degen_not_inside: assert property (@(posedge clk) disable iff (!arst_n)
		wt_valid && wt.degenerate |-> !wt.inside_res)
		else $error("degenerate result flagged inside");

	// A point inside has no negative weight.
	a_inside_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		wt_valid && wt.inside_res |->
			!wt.weight_a[bpit_pkg::WEIGHT_W-1] && !wt.weight_b[bpit_pkg::WEIGHT_W-1] &&
			!wt.weight_c[bpit_pkg::WEIGHT_W-1])
		else $error("inside result has a negative weight");

	// A frozen pipeline keeps the waiting result in place.
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		wt_valid && wt_stall |=> wt_valid && $stable(wt))
		else $error("stalled result changed");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for barycentric_point_in_triangle: directed and random
// triangles, random idling on both channels, one long result hold-off.
// Depends on bpit_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;

	// Keeps the weights expected for accepted points and checks results in order.
	class bpit_scoreboard;
		localparam longint SAT_POS = (longint'(1) <<< (bpit_pkg::WEIGHT_W - 1)) - 1;
		localparam longint SAT_NEG_MAG = longint'(1) <<< (bpit_pkg::WEIGHT_W - 1);

		bpit_pkg::wt_t expected_weights[$];
		int mismatches;
		int results_seen;

		function new();
			mismatches = 0;
			results_seen = 0;
		endfunction

		// Rounded quotient n * 2^WEIGHT_FRAC_DEF / d, ties away from zero, saturated; d > 0.
		function logic signed [bpit_pkg::WEIGHT_W-1:0] scaled_weight(longint n, longint d);
			longint mag;
			longint q;
			bit neg;
			neg = n < 0;
			mag = neg ? -n : n;
			q = ((mag <<< bpit_pkg::WEIGHT_FRAC_DEF) * 2 + d) / (2 * d);
			if (!neg) begin
				if (q > SAT_POS) q = SAT_POS;
			end else begin
				if (q > SAT_NEG_MAG) q = SAT_NEG_MAG;
				q = -q;
			end
			return q[bpit_pkg::WEIGHT_W-1:0];
		endfunction

		// Weights from cross products of the edge vectors, exact until the division.
		function bpit_pkg::wt_t predict_weights(bpit_pkg::pt_t p);
			longint e0u, e0v, e1u, e1v, e2u, e2v;
			longint area, nb, nc, na;
			bpit_pkg::wt_t w;
			e0u = longint'(p.vert_b_u) - longint'(p.vert_a_u);
			e0v = longint'(p.vert_b_v) - longint'(p.vert_a_v);
			e1u = longint'(p.vert_c_u) - longint'(p.vert_a_u);
			e1v = longint'(p.vert_c_v) - longint'(p.vert_a_v);
			e2u = longint'(p.point_u) - longint'(p.vert_a_u);
			e2v = longint'(p.point_v) - longint'(p.vert_a_v);
			area = e0u * e1v - e0v * e1u;
			nb = e2u * e1v - e2v * e1u;
			nc = e0u * e2v - e0v * e2u;
			w = '0;
			if (area == 0) begin
				w.degenerate = 1'b1;
				return w;
			end
			// A clockwise triangle gives the same weights once all signs flip.
			if (area < 0) begin
				area = -area;
				nb = -nb;
				nc = -nc;
			end
			na = area - nb - nc;
			w.weight_a = scaled_weight(na, area);
			w.weight_b = scaled_weight(nb, area);
			w.weight_c = scaled_weight(nc, area);
			w.inside_res = (na >= 0 && nb >= 0 && nc >= 0);
			return w;
		endfunction

		function void note_point(bpit_pkg::pt_t p);
			expected_weights.insert(expected_weights.size(), predict_weights(p));
		endfunction

		function int pending();
			return expected_weights.size();
		endfunction

		task report(string msg);
			mismatches++;
			$display("mismatch: %s", msg);
		endtask

		task check_weights(bpit_pkg::wt_t got);
			bpit_pkg::wt_t want;
			if (expected_weights.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results_seen));
				results_seen++;
				return;
			end
			want = expected_weights.pop_front();
			if (got.weight_a !== want.weight_a)
				report($sformatf("result %0d weight_a %0d, expected %0d",
					results_seen, got.weight_a, want.weight_a));
			if (got.weight_b !== want.weight_b)
				report($sformatf("result %0d weight_b %0d, expected %0d",
					results_seen, got.weight_b, want.weight_b));
			if (got.weight_c !== want.weight_c)
				report($sformatf("result %0d weight_c %0d, expected %0d",
					results_seen, got.weight_c, want.weight_c));
			if (got.inside_res !== want.inside_res)
				report($sformatf("result %0d inside_res %b, expected %b",
					results_seen, got.inside_res, want.inside_res));
			if (got.degenerate !== want.degenerate)
				report($sformatf("result %0d degenerate %b, expected %b",
					results_seen, got.degenerate, want.degenerate));
			results_seen++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pt_valid = 1'b0;
	logic pt_stall;
	bpit_pkg::pt_t pt = '0;
	logic wt_valid;
	logic wt_stall = 1'b0;
	bpit_pkg::wt_t wt;

	bpit_scoreboard sb;
	int n_sent = 0;

	barycentric_point_in_triangle u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt(pt),
		.wt_valid(wt_valid),
		.wt_stall(wt_stall),
		.wt(wt)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic bpit_pkg::pt_t make_point(int pu, int pv, int au, int av,
		int bu, int bv, int cu, int cv);
		bpit_pkg::pt_t p;
		p.point_u = pu[bpit_pkg::COORD_W-1:0];
		p.point_v = pv[bpit_pkg::COORD_W-1:0];
		p.vert_a_u = au[bpit_pkg::COORD_W-1:0];
		p.vert_a_v = av[bpit_pkg::COORD_W-1:0];
		p.vert_b_u = bu[bpit_pkg::COORD_W-1:0];
		p.vert_b_v = bv[bpit_pkg::COORD_W-1:0];
		p.vert_c_u = cu[bpit_pkg::COORD_W-1:0];
		p.vert_c_v = cv[bpit_pkg::COORD_W-1:0];
		return p;
	endfunction

	// Offers one transaction after a random gap and holds it until accepted.
	task automatic send_point(input bpit_pkg::pt_t p);
		int gap;
		gap = (n_sent >= 400 && n_sent < 550) ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			pt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt <= p;
		pt_valid <= 1'b1;
		do @(posedge clk); while (pt_stall);
		sb.note_point(p);
		n_sent++;
	endtask

	// Result side: random stalls per transaction, a stall-free stretch and
	// one long hold-off that backs the pipeline up into the input.
	initial begin
		int n_taken;
		int hold;
		n_taken = 0;
		// Results are only watched once reset has been released.
		wait (arst_n === 1'b1);
		forever begin
			if (n_taken == 250)
				hold = 200;
			else if (n_taken >= 450 && n_taken < 600)
				hold = 0;
			else
				hold = $urandom_range(0, 3);
			if (hold > 0) begin
				wt_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			wt_stall <= 1'b0;
			do @(posedge clk); while (!wt_valid);
			sb.check_weights(wt);
			n_taken++;
		end
	end

	// Main sequence: reset, directed cases, random triangles, drain.
	initial begin
		int kind, sel, k;
		int r0, r1, r2, rsum;
		int au, av, bu, bv, cu, cv, pu, pv, du, dv;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All zero and all ones: both degenerate.
		send_point(make_point(0, 0, 0, 0, 0, 0, 0, 0));
		send_point(make_point('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
			'hFFFF, 'hFFFF));
		// Right triangle, counterclockwise and clockwise, point inside.
		send_point(make_point('h2000, 'h2000, 0, 0, 'h8000, 0, 0, 'h8000));
		send_point(make_point('h2000, 'h2000, 0, 0, 0, 'h8000, 'h8000, 0));
		// Point on each vertex, on the hypotenuse, and outside.
		send_point(make_point(0, 0, 0, 0, 'h8000, 0, 0, 'h8000));
		send_point(make_point('h8000, 0, 0, 0, 'h8000, 0, 0, 'h8000));
		send_point(make_point(0, 'h8000, 0, 0, 'h8000, 0, 0, 'h8000));
		send_point(make_point('h4000, 'h4000, 0, 0, 'h8000, 0, 0, 'h8000));
		send_point(make_point('h8000, 'h8000, 0, 0, 'h8000, 0, 0, 'h8000));
		// Tiny triangles with a far point: weights saturate both ways.
		send_point(make_point('hFFFF, 'hFFFF, 0, 0, 1, 0, 0, 1));
		send_point(make_point('hFFFF, 0, 0, 0, 0, 1, 1, 0));
		// Collinear and coincident vertices.
		send_point(make_point('h500, 'h700, 0, 0, 'h1000, 'h1000, 'h2000, 'h2000));
		send_point(make_point('h1234, 'h4321, 'h3000, 'h3000, 'h3000, 'h3000,
			'h7000, 'h1000));
		// Largest triangles, two placements, both counterclockwise.
		send_point(make_point('hFFFF, 'hFFFF, 0, 0, 'hFFFF, 0, 0, 'hFFFF));
		send_point(make_point(0, 0, 'hFFFF, 'hFFFF, 0, 'hFFFF, 'hFFFF, 0));
		// Exact halves in the quotient: rounding ties, positive and negative.
		send_point(make_point(1, 0, 0, 0, 'h8000, 0, 0, 3));
		send_point(make_point(0, 0, 1, 0, 'h8001, 0, 1, 3));
		// Coordinates above 1.0.
		send_point(make_point('hC000, 'hC000, 'h8001, 'h8001, 'hFFFF, 'h8001,
			'h8001, 'hFFFF));

		repeat (900) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				// Unrestricted 16-bit fields.
				pu = $urandom_range(0, 'hFFFF);
				pv = $urandom_range(0, 'hFFFF);
				au = $urandom_range(0, 'hFFFF);
				av = $urandom_range(0, 'hFFFF);
				bu = $urandom_range(0, 'hFFFF);
				bv = $urandom_range(0, 'hFFFF);
				cu = $urandom_range(0, 'hFFFF);
				cv = $urandom_range(0, 'hFFFF);
			end else if (kind < 70) begin
				// Point as a weighted mix of the vertices, sometimes pushed out.
				au = $urandom_range(0, 'h8000);
				av = $urandom_range(0, 'h8000);
				bu = $urandom_range(0, 'h8000);
				bv = $urandom_range(0, 'h8000);
				cu = $urandom_range(0, 'h8000);
				cv = $urandom_range(0, 'h8000);
				r0 = $urandom_range(0, 255);
				r1 = $urandom_range(0, 255);
				r2 = $urandom_range(0, 255);
				rsum = r0 + r1 + r2 + 1;
				pu = (au * r0 + bu * r1 + cu * r2 + au) / rsum;
				pv = (av * r0 + bv * r1 + cv * r2 + av) / rsum;
				if ($urandom_range(0, 3) == 0) begin
					pu = pu + int'($urandom_range(0, 1024)) - 512;
					pv = pv + int'($urandom_range(0, 1024)) - 512;
				end
			end else if (kind < 85) begin
				// Small triangle: large weights and saturation.
				au = $urandom_range(64, 'hFFFF - 128);
				av = $urandom_range(64, 'hFFFF - 128);
				bu = au + int'($urandom_range(0, 63));
				bv = av + int'($urandom_range(0, 63));
				cu = au + int'($urandom_range(0, 63));
				cv = av + int'($urandom_range(0, 63));
				pu = au + int'($urandom_range(0, 127)) - 32;
				pv = av + int'($urandom_range(0, 127)) - 32;
			end else if (kind < 95) begin
				// Vertices on one line.
				au = $urandom_range(4000, 61000);
				av = $urandom_range(4000, 61000);
				du = int'($urandom_range(0, 4000)) - 2000;
				dv = int'($urandom_range(0, 4000)) - 2000;
				k = int'($urandom_range(0, 4)) - 2;
				bu = au + du;
				bv = av + dv;
				cu = au + k * du;
				cv = av + k * dv;
				pu = $urandom_range(0, 'hFFFF);
				pv = $urandom_range(0, 'hFFFF);
			end else begin
				// Point on a vertex or an edge midpoint.
				au = $urandom_range(0, 'hFFFF);
				av = $urandom_range(0, 'hFFFF);
				bu = $urandom_range(0, 'hFFFF);
				bv = $urandom_range(0, 'hFFFF);
				cu = $urandom_range(0, 'hFFFF);
				cv = $urandom_range(0, 'hFFFF);
				sel = $urandom_range(0, 5);
				case (sel)
					0: begin pu = au; pv = av; end
					1: begin pu = bu; pv = bv; end
					2: begin pu = cu; pv = cv; end
					3: begin pu = (au + bu) >> 1; pv = (av + bv) >> 1; end
					4: begin pu = (bu + cu) >> 1; pv = (bv + cv) >> 1; end
					default: begin pu = (au + cu) >> 1; pv = (av + cv) >> 1; end
				endcase
			end
			send_point(make_point(pu, pv, au, av, bu, bv, cu, cv));
		end
		pt_valid <= 1'b0;

		// Wait for every expected transaction, then watch for strays.
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Timeout well beyond the slowest correct run.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- barycentric_point_in_triangle.f -----
sv/bpit_pkg.sv
sv/bpit_div.sv
sv/barycentric_point_in_triangle.sv
tb/testbench.sv
